FILE: rtl/escaped_frame_receiver_checksum_core_defines.svh
// Assertion macros for the escaped frame receiver checksum core.
// Header only; included by files that carry concurrent assertions.
`ifndef ESCAPED_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CHECKSUM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define EFRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efrc assertion failed");

// Next-cycle implication.
`define EFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efrc assertion failed");

`endif

FILE: rtl/efrc_pkg.sv
// Package for the escaped frame receiver checksum core.
// Framing codes, limits, status codes and the result record; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efrc_pkg;

  // Largest number of decoded bytes a frame may hold.
  localparam int unsigned MaxFrame = 256;

  localparam int unsigned LenW   = 9;
  localparam int unsigned CntReq = $clog2(MaxFrame + 1);
  localparam int unsigned CntW   = (CntReq > LenW) ? CntReq : LenW;
  localparam int unsigned LenMax = (1 << LenW) - 1;

  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EndByte   = 8'hFF;
  localparam logic [7:0] EscByte   = 8'h8C;
  localparam logic [7:0] EscStart  = 8'h81;
  localparam logic [7:0] EscEnd    = 8'h00;
  localparam logic [7:0] EscEsc    = 8'h73;

  typedef enum logic [2:0] {
    StGood     = 3'd0,
    StShort    = 3'd1,
    StBadSum   = 3'd2,
    StAddr     = 3'd3,
    StOverflow = 3'd4
  } status_e;

  typedef enum logic {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    status_e           status;
    logic [LenW-1:0]   frame_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/efrc_if.sv
// Valid/ready channel interfaces for the escaped frame receiver core.
// Depends on efrc_pkg for the length width.
`timescale 1ns / 1ps
`default_nettype none

interface efrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efrc_res_if import efrc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [7:0]      data_byte;
  logic [2:0]      status;
  logic [LenW-1:0] frame_length;

  modport source (output valid, output kind, output data_byte, output status,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input frame_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/escaped_frame_receiver_checksum_core.sv
// Channel   | Dir | Payload                                   | Handshake
// rx_i      | in  | rx_byte[7:0]                              | valid/ready
// res_o     | out | kind, data_byte, status, frame_length[8:0] | valid/ready
// cfg       | in  | cfg_wdata_i[7:0] (own address)            | cfg_we_i
//
// One item per cycle while rx_i.ready is high: each raw byte is decoded, checked
// and folded into the frame state in the cycle it is taken; its result, if any,
// lands in the output register. rx_i.ready drops only while a result sits in
// the output register and res_o.ready is low. Reset is asynchronous, active low,
// and leaves the block outside a frame with the own address at zero.
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_frame_receiver_checksum_core_defines.svh"

module escaped_frame_receiver_checksum_core import efrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  efrc_rx_if.sink         rx_i,
  efrc_res_if.source      res_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     sum_q, sum_d;
  logic [15:0]     last_q, last_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      own_addr_q;

  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            accept;
  logic [7:0]      b;
  logic            keep;
  logic [7:0]      dec;
  logic            emit;
  result_t         res;
  status_e         end_st;
  logic [LenW-1:0] len_sat;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign len_sat = (count_q > CntW'(LenMax)) ? LenW'(LenMax) : count_q[LenW-1:0];

  // Checksum is sent low byte first; it is tested before the address.
  always_comb begin
    if (count_q < CntW'(3)) begin
      end_st = StShort;
    end else if (last_q[15:8] != sum_q[7:0] || last_q[7:0] != sum_q[15:8]) begin
      end_st = StBadSum;
    end else if (first_q != own_addr_q) begin
      end_st = StAddr;
    end else begin
      end_st = StGood;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    count_d    = count_q;
    sum_d      = sum_q;
    last_d     = last_q;
    first_d    = first_q;
    emit       = 1'b0;
    keep       = 1'b0;
    dec        = b;
    res        = '{kind: KindData, data_byte: 8'h00, status: StGood,
                   frame_length: '0};

    if (accept) begin
      if (b == StartByte) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        count_d    = '0;
        sum_d      = '0;
        last_d     = '0;
        first_d    = '0;
      end else if (in_frame_q) begin
        if (count_q >= CntW'(MaxFrame)) begin
          emit       = 1'b1;
          res.kind   = KindStatus;
          res.status = StOverflow;
          res.frame_length = len_sat;
        end else if (esc_q && b == EscStart) begin
          keep = 1'b1;
          dec  = StartByte;
        end else if (esc_q && b == EscEnd) begin
          keep = 1'b1;
          dec  = EndByte;
        end else if (esc_q && b == EscEsc) begin
          keep = 1'b1;
          dec  = EscByte;
        end else if (b != EscByte && b != EndByte) begin
          keep = 1'b1;
        end else if (b == EndByte) begin
          emit       = 1'b1;
          res.kind   = KindStatus;
          res.status = end_st;
          res.frame_length = len_sat;
        end

        if (emit) begin
          // frame closed: overflow or end byte
          in_frame_d = 1'b0;
          esc_d      = 1'b0;
          count_d    = '0;
          sum_d      = '0;
          last_d     = '0;
          first_d    = '0;
        end else begin
          esc_d = (b == EscByte);
        end

        if (keep) begin
          emit          = 1'b1;
          res.data_byte = dec;
          // bytes older than the last two go into the sum
          if (count_q >= CntW'(2)) begin
            sum_d = sum_q + {8'h00, last_q[15:8]};
          end
          last_d = {last_q[7:0], dec};
          if (count_q == '0) begin
            first_d = dec;
          end
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rx_i.ready) begin
      out_valid_d = emit;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      first_q     <= '0;
      own_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      esc_q       <= esc_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.status       = out_q.status;
  assign res_o.frame_length = out_q.frame_length;

  `EFRC_ASSERT_NOW(a_stall_blocks_rx, clk_i, rst_ni, res_o.valid && !res_o.ready, !rx_i.ready)
  `EFRC_ASSERT_NOW(a_idle_state_clear, clk_i, rst_ni, !in_frame_q, count_q == '0 && sum_q == '0)
  `EFRC_ASSERT_NOW(a_count_limit, clk_i, rst_ni, in_frame_q, count_q <= CntW'(MaxFrame))
  `EFRC_ASSERT_NOW(a_data_fields_zero, clk_i, rst_ni, res_o.valid && res_o.kind == KindData, res_o.status == StGood && res_o.frame_length == '0)
  `EFRC_ASSERT_NEXT(a_start_opens, clk_i, rst_ni, accept && b == StartByte, in_frame_q && count_q == '0 && !out_valid_q)

endmodule

`default_nettype wire
